### design/plix_pkg.sv
package plix_pkg;

    // default sizes for the top-level parameters
    localparam int LIST_DEPTH_DEF = 1024;
    localparam int MAX_LISTS_DEF  = 4;

    // command queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

    // action codes as they arrive in tuser
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_PROBE = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // classified command; list_count already saturated to the list count
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  list_id;
        logic [31:0] value;
        logic [2:0]  count;
    } t_cmd;

endpackage

### design/plix_front.sv
module plix_front #(
    parameter int MAX_LISTS = plix_pkg::MAX_LISTS_DEF
) (
    input  logic              i_valid,
    input  logic [1:0]        i_action,
    input  logic [1:0]        i_list_id,
    input  logic [31:0]       i_value,
    input  logic [2:0]        i_count,
    input  logic              i_full,
    output logic              o_ready,
    output logic              o_push,
    output plix_pkg::t_cmd    o_cmd
);

    logic keep;

    // loads to a list that does not exist and the unused action are dropped here
    always_comb begin
        keep = 1'b0;
        case (i_action)
            plix_pkg::ACT_LOAD:  keep = (32'(i_list_id) < MAX_LISTS);
            plix_pkg::ACT_PROBE: keep = 1'b1;
            plix_pkg::ACT_CLEAR: keep = 1'b1;
            default:             keep = 1'b0;
        endcase
    end

    always_comb begin
        o_cmd.kind    = i_action;
        o_cmd.list_id = i_list_id;
        o_cmd.value   = i_value;
        if (32'(i_count) > MAX_LISTS) begin
            o_cmd.count = 3'(MAX_LISTS);
        end else begin
            o_cmd.count = i_count;
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full && keep;

endmodule

### design/plix_fifo.sv
module plix_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  plix_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output plix_pkg::t_cmd    o_cmd,
    output logic              o_full,
    output logic              o_empty
);

    localparam int CW = $clog2(plix_pkg::FIFO_DEPTH + 1);

    plix_pkg::t_cmd                  r_mem [plix_pkg::FIFO_DEPTH];
    logic [plix_pkg::FIFO_AW-1:0]    r_wp;
    logic [plix_pkg::FIFO_AW-1:0]    r_rp;
    logic [CW-1:0]                   r_cnt;

    assign o_full  = (r_cnt == CW'(plix_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (32'(r_wp) == plix_pkg::FIFO_DEPTH - 1) ? '0
                        : plix_pkg::FIFO_AW'(r_wp + 1'b1);
            end
            if (i_pop) begin
                r_rp <= (32'(r_rp) == plix_pkg::FIFO_DEPTH - 1) ? '0
                        : plix_pkg::FIFO_AW'(r_rp + 1'b1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= CW'(r_cnt + 1'b1);
                2'b01:   r_cnt <= CW'(r_cnt - 1'b1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### design/plix_back.sv
module plix_back #(
    parameter int LIST_DEPTH = plix_pkg::LIST_DEPTH_DEF,
    parameter int MAX_LISTS  = plix_pkg::MAX_LISTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  plix_pkg::t_cmd    i_cmd,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_value,
    output logic              o_in_all
);

    localparam int DW        = $clog2(LIST_DEPTH);
    localparam int LENW      = $clog2(LIST_DEPTH + 1);
    localparam int LW        = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
    localparam int AW        = LW + DW;
    localparam int MEM_DEPTH = MAX_LISTS * (2 ** DW);
    localparam logic [LENW-1:0] FULL = LENW'(LIST_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state            r_state;
    logic [LW-1:0]     r_list;
    logic [LENW-1:0]   r_idx;
    logic [31:0]       r_val;
    logic [2:0]        r_cnt;
    logic [LENW-1:0]   r_len [MAX_LISTS];
    logic              r_rd_vld;
    logic [31:0]       r_rd_data;
    logic              r_out_vld;
    logic [31:0]       r_out_val;
    logic              r_out_hit;

    logic [31:0]       r_mem [MEM_DEPTH];

    logic [LW-1:0]     sel_list;
    logic [LENW-1:0]   len_sel;
    logic              found;
    logic              issue;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic              last_list;
    logic              scan_done;
    logic              out_set;

    // one length read port: the queue head in idle, the list being scanned otherwise
    assign sel_list  = (r_state == S_IDLE) ? LW'(i_cmd.list_id) : r_list;
    assign len_sel   = r_len[sel_list];
    assign found     = r_rd_vld && (r_rd_data == r_val);
    assign issue     = (r_state == S_SCAN) && !found && (r_idx < len_sel);
    assign last_list = ((4'(r_list) + 4'd1) == 4'(r_cnt));

    // a probe leaves the queue only when the result slot is free at its start
    assign o_pop = (r_state == S_IDLE) && !i_empty &&
                   ((i_cmd.kind != plix_pkg::ACT_PROBE) || !r_out_vld || i_ready);

    // scan ends on a hit in the last list or on a list exhausted without a hit
    assign scan_done = (r_state == S_SCAN) && (found ? last_list : !issue);
    assign out_set   = scan_done ||
                       (o_pop && (i_cmd.kind == plix_pkg::ACT_PROBE) && (i_cmd.count == 3'd0));

    assign wr_en   = o_pop && (i_cmd.kind == plix_pkg::ACT_LOAD) && (len_sel < FULL);
    assign wr_addr = {LW'(i_cmd.list_id), len_sel[DW-1:0]};
    assign rd_addr = {r_list, r_idx[DW-1:0]};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_cmd.value;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < MAX_LISTS; i++) begin
                r_len[i] <= '0;
            end
        end else begin
            r_out_vld <= out_set || (r_out_vld && !i_ready);
            r_rd_vld  <= issue;
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        case (i_cmd.kind)
                            plix_pkg::ACT_LOAD: begin
                                if (len_sel < FULL) begin
                                    r_len[sel_list] <= LENW'(len_sel + 1'b1);
                                end
                            end
                            plix_pkg::ACT_CLEAR: begin
                                for (int i = 0; i < MAX_LISTS; i++) begin
                                    r_len[i] <= '0;
                                end
                            end
                            plix_pkg::ACT_PROBE: begin
                                r_val  <= i_cmd.value;
                                r_cnt  <= i_cmd.count;
                                r_list <= '0;
                                r_idx  <= '0;
                                if (i_cmd.count == 3'd0) begin
                                    r_out_val <= i_cmd.value;
                                    r_out_hit <= 1'b0;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (found) begin
                        // this list holds the value: finish or move to the next list
                        if (last_list) begin
                            r_out_val <= r_val;
                            r_out_hit <= 1'b1;
                            r_state   <= S_IDLE;
                        end else begin
                            r_list <= LW'(r_list + 1'b1);
                            r_idx  <= '0;
                        end
                    end else if (issue) begin
                        r_idx <= LENW'(r_idx + 1'b1);
                    end else begin
                        // list exhausted (or empty) without a hit
                        r_out_val <= r_val;
                        r_out_hit <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid  = r_out_vld;
    assign o_value  = r_out_val;
    assign o_in_all = r_out_hit;

endmodule

### design/posting_list_intersect_by_element_top.sv
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser: action; tdata: list_id, value, list_count
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: probed_value, in_all
//
// Load and clear words are done by the back end straight from idle; a probe scans
// lists 0 to list_count-1 in order, reading at most MAX_LISTS*LIST_DEPTH entries
// through the single read port of the list memory (one entry per cycle).
// Reset clears list lengths, the command queue and the result slot; no memory sweep.
// The front keeps taking words while the two-entry queue has room, even while a
// result waits on m_axis; a probe starts only once the result slot is free.
module posting_list_intersect_by_element_top #(
    parameter int LIST_DEPTH = plix_pkg::LIST_DEPTH_DEF,
    parameter int MAX_LISTS  = plix_pkg::MAX_LISTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [1:0] list_id, [33:2] value, [36:34] list_count
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [31:0] probed_value, [32] in_all
);

    plix_pkg::t_cmd  front_cmd;
    plix_pkg::t_cmd  head_cmd;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    logic [31:0]     out_value;
    logic            out_in_all;

    // front: decode, drop no-op words, saturate list_count
    plix_front #(
        .MAX_LISTS (MAX_LISTS)
    ) u_front (
        .i_valid   (s_axis_tvalid),
        .i_action  (s_axis_tuser),
        .i_list_id (s_axis_tdata[1:0]),
        .i_value   (s_axis_tdata[33:2]),
        .i_count   (s_axis_tdata[36:34]),
        .i_full    (full),
        .o_ready   (s_axis_tready),
        .o_push    (push),
        .o_cmd     (front_cmd)
    );

    // short command queue decoupling front from the scan engine
    plix_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    // back: list memory, lengths, scan sequencer and result register
    plix_back #(
        .LIST_DEPTH (LIST_DEPTH),
        .MAX_LISTS  (MAX_LISTS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (head_cmd),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_value  (out_value),
        .o_in_all (out_in_all)
    );

    assign m_axis_tdata = {7'd0, out_in_all, out_value};

endmodule
